// ----- rtl/tfpd_pkg.sv -----
// Shared types, codes and distance helpers for the two-finger pinch detector.
package tfpd_pkg;

	localparam int COORD_BITS = 16;
	localparam int SPAN_W     = COORD_BITS + 1;
	localparam int DIFF_W     = COORD_BITS + 2;
	localparam int THR_W      = 17;
	localparam int CMP_W      = ((DIFF_W > THR_W) ? DIFF_W : THR_W) + 1;
	localparam int FC_W       = 4;
	localparam logic [FC_W-1:0] FC_MAX = FC_W'(15);
	localparam logic [FC_W-1:0] FC_TWO = FC_W'(2);
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(240);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [SPAN_W-1:0]     span_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic [THR_W-1:0]      thr_t;
	typedef logic [FC_W-1:0]       fcount_t;

	typedef enum logic [2:0] {
		OP_DOWN   = 3'd0,
		OP_MOTION = 3'd1,
		OP_UP     = 3'd2,
		OP_FRAME  = 3'd3,
		OP_CANCEL = 3'd4,
		OP_RESET  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IGNORE    = 3'd0,
		ST_MAYBE     = 3'd1,
		ST_CANCELLED = 3'd2,
		ST_FINISHED  = 3'd3,
		ST_UPDATE    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_IN   = 2'd1,
		DIR_OUT  = 2'd2
	} dir_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	// Request as held in the input register
	typedef struct packed {
		logic [2:0] op;
		logic       slot;
		point_t     pt;
	} req_t;

	// Partial result handed from the gesture core to the result stage
	typedef struct packed {
		status_t status;
		dir_t    recent;
		diff_t   overall_diff;
	} part_t;

	function automatic coord_t abs_diff(input coord_t a, input coord_t b);
		return (a > b) ? coord_t'(a - b) : coord_t'(b - a);
	endfunction

	function automatic span_t span(input point_t p0, input point_t p1);
		return span_t'({1'b0, abs_diff(p0.x, p1.x)}) + span_t'({1'b0, abs_diff(p0.y, p1.y)});
	endfunction

	function automatic diff_t span_diff(input span_t a, input span_t b);
		return diff_t'({1'b0, a}) - diff_t'({1'b0, b});
	endfunction

	function automatic logic signed [CMP_W-1:0] diff_ext(input diff_t d);
		return {{(CMP_W-DIFF_W){d[DIFF_W-1]}}, d};
	endfunction

	function automatic logic signed [CMP_W-1:0] thr_ext(input thr_t t);
		return {{(CMP_W-THR_W){1'b0}}, t};
	endfunction

endpackage

// ----- rtl/tfpd_gesture_core.sv -----
// Gesture state and per-request update, with the stage-two result register.
module tfpd_gesture_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  tfpd_pkg::req_t req_s1,
	input  tfpd_pkg::thr_t threshold,
	output tfpd_pkg::part_t part_s2
);
	import tfpd_pkg::*;

	fcount_t      fc_q;
	logic         canc_q;
	logic         started_q;
	dir_t         ldir_q;
	point_t [1:0] sp_q;
	point_t [1:0] pp_q;
	point_t [1:0] cp_q;

	fcount_t      fc_n;
	logic         canc_n;
	logic         started_n;
	dir_t         ldir_n;
	point_t [1:0] sp_n;
	point_t [1:0] pp_n;
	point_t [1:0] cp_n;
	status_t      st_n;
	diff_t        frame_d;
	logic signed [CMP_W-1:0] fd_ext;
	logic signed [CMP_W-1:0] t_ext;

	always_comb begin
		fc_n      = fc_q;
		canc_n    = canc_q;
		started_n = started_q;
		ldir_n    = ldir_q;
		sp_n      = sp_q;
		pp_n      = pp_q;
		cp_n      = cp_q;
		st_n      = ST_IGNORE;
		frame_d   = span_diff(span(cp_q[0], cp_q[1]), span(pp_q[0], pp_q[1]));
		fd_ext    = diff_ext(frame_d);
		t_ext     = thr_ext(threshold);

		case (op_t'(req_s1.op))
			OP_DOWN: begin
				if (fc_q != FC_MAX)
					fc_n = fc_q + FC_W'(1);
				if (!canc_q) begin
					if (fc_n <= FC_TWO)
						sp_n[req_s1.slot] = req_s1.pt;
					if (fc_n == FC_TWO) begin
						started_n = 1'b1;
						pp_n      = sp_n;
						cp_n      = sp_n;
						st_n      = ST_MAYBE;
					end else if (fc_n > FC_TWO) begin
						canc_n = 1'b1;
						st_n   = ST_CANCELLED;
					end
				end
			end
			OP_MOTION: begin
				if (!canc_q) begin
					cp_n[req_s1.slot] = req_s1.pt;
					if (!started_q)
						sp_n[req_s1.slot] = req_s1.pt;
				end
			end
			OP_UP: begin
				if (fc_q != '0)
					fc_n = fc_q - FC_W'(1);
				if (fc_n == '0) begin
					if (!canc_q && started_q && ldir_q != DIR_NONE) begin
						st_n = ST_FINISHED;
					end else begin
						canc_n    = 1'b0;
						started_n = 1'b0;
						ldir_n    = DIR_NONE;
						sp_n      = '0;
						pp_n      = '0;
						cp_n      = '0;
					end
				end
			end
			OP_FRAME: begin
				if (!canc_q && started_q && fc_q == FC_TWO &&
				    (fd_ext >= t_ext || fd_ext <= -t_ext)) begin
					pp_n   = cp_q;
					ldir_n = (frame_d > 0) ? DIR_IN : DIR_OUT;
					st_n   = ST_UPDATE;
				end
			end
			OP_CANCEL: begin
				canc_n = 1'b1;
				st_n   = ST_CANCELLED;
			end
			OP_RESET: begin
				canc_n    = 1'b0;
				started_n = 1'b0;
				ldir_n    = DIR_NONE;
				sp_n      = '0;
				pp_n      = '0;
				cp_n      = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q      <= '0;
			canc_q    <= 1'b0;
			started_q <= 1'b0;
			ldir_q    <= DIR_NONE;
			sp_q      <= '0;
			pp_q      <= '0;
			cp_q      <= '0;
		end else if (take) begin
			fc_q      <= fc_n;
			canc_q    <= canc_n;
			started_q <= started_n;
			ldir_q    <= ldir_n;
			sp_q      <= sp_n;
			pp_q      <= pp_n;
			cp_q      <= cp_n;
		end
	end

	// overall comparison against the threshold is finished in the result stage
	always_ff @(posedge clk) begin
		if (take) begin
			part_s2.status       <= st_n;
			part_s2.recent       <= ldir_n;
			part_s2.overall_diff <= span_diff(span(cp_n[0], cp_n[1]), span(sp_n[0], sp_n[1]));
		end
	end

endmodule

// ----- rtl/tfpd_result_stage.sv -----
// Output register: resolves the start-to-current direction and holds the result.
module tfpd_result_stage (
	input  logic            clk,
	input  logic            load,
	input  tfpd_pkg::part_t part_s2,
	input  tfpd_pkg::thr_t  threshold,
	output logic [2:0]      status,
	output logic [1:0]      recent_direction,
	output logic [1:0]      overall_direction
);
	import tfpd_pkg::*;

	logic signed [CMP_W-1:0] d_ext;
	logic signed [CMP_W-1:0] t_ext;
	dir_t                    overall;

	always_comb begin
		d_ext = diff_ext(part_s2.overall_diff);
		t_ext = thr_ext(threshold);
		if (d_ext > t_ext)
			overall = DIR_IN;
		else if (d_ext < -t_ext)
			overall = DIR_OUT;
		else
			overall = DIR_NONE;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status            <= part_s2.status;
			recent_direction  <= part_s2.recent;
			overall_direction <= overall;
		end
	end

endmodule

// ----- rtl/two_finger_pinch_detector.sv -----
// Top level of the two-finger pinch detector: input register, handshake and threshold.
//
// Takes one touch request per cycle while the output is not stalled and returns exactly one
// result per request. A request passes the input register, the gesture update and the output
// register before its result is on the outputs. Sustained rate is one request per clock while
// the output is not stalled: the gesture state is read and rewritten while a request is in the
// update stage, so consecutive requests see each other's effect without a bubble. The pipeline
// stalls only when a result is held at the output and out_ready is low. The threshold thr_q
// resets to 240 and is written through cfg_we/cfg_wdata; the user must write it only while no
// request is in flight, and the block itself does not enforce this.
module two_finger_pinch_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic        slot,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [1:0]  recent_direction,
	output logic [1:0]  overall_direction,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata
);
	import tfpd_pkg::*;

	thr_t  thr_q;
	req_t  req_s1;
	logic  v_s1;
	logic  v_s2;
	part_t part_s2;
	logic  out_free;
	logic  s2_free;
	logic  take;
	logic  accept;

	assign out_free = !out_valid || out_ready;
	assign s2_free  = !v_s2 || out_free;
	assign take     = v_s1 && s2_free;
	assign in_ready = !v_s1 || s2_free;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THR_RESET;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we)
				thr_q <= cfg_wdata;
			if (in_ready)
				v_s1 <= in_valid;
			if (s2_free)
				v_s2 <= v_s1;
			if (out_free)
				out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.op   <= operation;
			req_s1.slot <= slot;
			req_s1.pt.x <= coord_t'(pos_x);
			req_s1.pt.y <= coord_t'(pos_y);
		end
	end

	tfpd_gesture_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.req_s1    (req_s1),
		.threshold (thr_q),
		.part_s2   (part_s2)
	);

	tfpd_result_stage u_result (
		.clk               (clk),
		.load              (v_s2 && out_free),
		.part_s2           (part_s2),
		.threshold         (thr_q),
		.status            (status),
		.recent_direction  (recent_direction),
		.overall_direction (overall_direction)
	);

endmodule

// ----- rtl/tfpd_checker.sv -----
// Port-level checks for the pinch detector, bound to the top level.
module tfpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic [1:0] recent_direction,
	input logic [1:0] overall_direction
);
	import tfpd_pkg::*;

	// a stalled result holds its fields
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(recent_direction) && $stable(overall_direction))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_IGNORE || status == ST_MAYBE ||
		status == ST_CANCELLED || status == ST_FINISHED || status == ST_UPDATE)
		else $error("unknown status code");

	// a zoom step or a finished gesture always carries a direction
	a_step_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_UPDATE || status == ST_FINISHED) |->
		recent_direction == DIR_IN || recent_direction == DIR_OUT)
		else $error("zoom step without direction");

	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> recent_direction != 2'd3 && overall_direction != 2'd3)
		else $error("unknown direction code");

endmodule

bind two_finger_pinch_detector tfpd_checker u_tfpd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.status            (status),
	.recent_direction  (recent_direction),
	.overall_direction (overall_direction)
);
